// ===== hdl/hea_pkg.sv =====
package hea_pkg;

    // field widths
    localparam int ANGLE_W = 32;
    localparam int COUNT_W = 32;
    localparam int UQ_W    = 16;
    localparam int HALL_W  = 3;
    localparam int CMD_W   = 2;
    localparam int MODE_W  = 2;
    localparam int APC_W   = 48;
    localparam int STEP_W  = 24;
    localparam int LIM_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INDEX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START = 2'd2;

    // modes
    localparam logic [MODE_W-1:0] MODE_HALL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ENC  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UQ_LIMIT        = 2'd2;

    // configuration reset values
    localparam logic [APC_W-1:0]  APC_RESET  = 48'd140737488355;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd53687;
    localparam logic [LIM_W-1:0]  LIM_RESET  = 15'd3000;

    // what the last stage does with the angle accumulator and offset
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_STEP,
        OP_ENC,
        OP_EDGE,
        OP_INDEX
    } t_op;

    // per-request control carried down the pipeline
    typedef struct packed {
        t_op               op;
        logic [ANGLE_W-1:0] addend;
        logic [MODE_W-1:0]  mode;
        logic [UQ_W-1:0]    uq;
    } t_ctl;

    // hall sector centre angles, 2^-32 turn
    function automatic logic [ANGLE_W-1:0] centre_angle(input logic [HALL_W-1:0] hall);
        logic [ANGLE_W-1:0] a;
        case (hall)
            3'd1:    a = 32'd1789569707;
            3'd2:    a = 32'd3221225472;
            3'd3:    a = 32'd2505397589;
            3'd4:    a = 32'd357913941;
            3'd5:    a = 32'd1073741824;
            3'd6:    a = 32'd3937053355;
            default: a = '0;
        endcase
        return a;
    endfunction

    // hall sector edge angles (centre minus 30 degrees)
    function automatic logic [ANGLE_W-1:0] edge_angle(input logic [HALL_W-1:0] hall);
        logic [ANGLE_W-1:0] a;
        case (hall)
            3'd1:    a = 32'd1431655765;
            3'd2:    a = 32'd2863311531;
            3'd3:    a = 32'd2147483648;
            3'd5:    a = 32'd715827883;
            3'd6:    a = 32'd3579139413;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/hea_angle_mul.sv =====
// Encoder count to angle: bits 47..16 of sign-extended count times scale,
// two pipeline stages (partial products, then sum).
module hea_angle_mul (
    input  logic                          i_clk,
    input  logic                          i_en_a,
    input  logic                          i_en_b,
    input  logic [hea_pkg::COUNT_W-1:0]   i_count,
    input  logic [hea_pkg::APC_W-1:0]     i_scale,
    output logic [hea_pkg::ANGLE_W-1:0]   o_angle
);

    logic [23:0] w_dl, w_dh, w_sl, w_sh;
    logic [47:0] w_ll;
    logic [23:0] w_hl, w_lh;
    logic [47:0] r_ll;
    logic [23:0] r_hl, r_lh;
    logic [23:0] w_cross;
    logic [47:0] w_sum;
    logic [hea_pkg::ANGLE_W-1:0] r_angle;

    // split operands in 24-bit halves; count is sign extended to 48 bits
    assign w_dl = i_count[23:0];
    assign w_dh = {{16{i_count[31]}}, i_count[31:24]};
    assign w_sl = i_scale[23:0];
    assign w_sh = i_scale[47:24];

    // cross products only matter in their low 24 bits
    assign w_ll = {24'd0, w_dl} * {24'd0, w_sl};
    assign w_hl = w_dh * w_sl;
    assign w_lh = w_dl * w_sh;

    // stage a: partial products, high-by-high drops out modulo 2^48
    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_ll <= w_ll;
            r_hl <= w_hl;
            r_lh <= w_lh;
        end
    end

    // stage b: combine and keep bits 47..16
    assign w_cross = r_hl + r_lh;
    assign w_sum   = r_ll + {w_cross, 24'd0};

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_angle <= w_sum[47:16];
        end
    end

    assign o_angle = r_angle;

endmodule

// ===== hdl/hall_encoder_angle_startup_top.sv =====
// Rotor electrical angle estimator for motor start-up (Hall plus ABZ encoder).
// Input stream: s_axis_tuser carries the command (tick, index, start),
// s_axis_tdata the Hall bits, encoder count and requested q voltage.
// Output stream: one result per request with the electrical angle, mode,
// encoder-ready flag and the clamped q voltage.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at the
// clock edge (0 angle_per_count, 1 startup_step, 2 uq_limit); write only
// while the block is idle.
// One request per cycle is sustained while the receiver takes results. The
// pipeline is an input register, the encoder scaling multiply split into
// partial products and a sum stage, and the accumulator update stage.
// Each pipeline stage moves on its own, so requests are still taken while
// a result waits; s_axis_tready drops only when all four registers are full
// and the receiver stalls.
// Reset (synchronous, active low) empties the pipeline, puts the estimator
// in hall-only mode with all angles, counts and offsets at zero, and loads
// the default configuration.
module hall_encoder_angle_startup_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [hea_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hea_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // hall_bits[2:0], enc_count[34:3], uq_request[50:35]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // rotor_angle[31:0], mode_now[33:32],
                                       // encoder_ready[34], uq_out[50:35]
);

    // configuration
    logic [hea_pkg::APC_W-1:0]  r_apc;
    logic [hea_pkg::STEP_W-1:0] r_step;
    logic [hea_pkg::LIM_W-1:0]  r_lim;

    // control state, updated at accept
    logic [hea_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [hea_pkg::HALL_W-1:0]  r_last_hall, n_last_hall;
    logic [hea_pkg::ANGLE_W-1:0] r_edge_angle, n_edge_angle;
    logic [hea_pkg::COUNT_W-1:0] r_edge_count, n_edge_count;

    // angle state, updated at result load
    logic [hea_pkg::ANGLE_W-1:0] r_acc, n_acc;
    logic [hea_pkg::ANGLE_W-1:0] r_offset, n_offset;

    // pipeline
    logic r_v1, r_v2, r_v3, r_vo;
    hea_pkg::t_ctl r_ctl1, r_ctl2, r_ctl3, n_ctl;
    logic [hea_pkg::COUNT_W-1:0] r_d1, n_d;
    logic [hea_pkg::ANGLE_W-1:0] w_prod;
    logic w_en1, w_en2, w_en3, w_eno, w_acc_in;

    // output register
    logic [hea_pkg::ANGLE_W-1:0] r_o_angle;
    logic [hea_pkg::MODE_W-1:0]  r_o_mode;
    logic                        r_o_ready;
    logic [hea_pkg::UQ_W-1:0]    r_o_uq;

    // input fields
    logic [hea_pkg::CMD_W-1:0]   w_cmd;
    logic [hea_pkg::HALL_W-1:0]  w_hall;
    logic [hea_pkg::COUNT_W-1:0] w_enc;
    logic [hea_pkg::UQ_W-1:0]    w_uq;
    logic                        w_hall_ok;

    // clamp
    logic signed [16:0] w_uq_x, w_lim_x, w_nlim_x;

    assign w_cmd  = s_axis_tuser[1:0];
    assign w_hall = s_axis_tdata[2:0];
    assign w_enc  = s_axis_tdata[34:3];
    assign w_uq   = s_axis_tdata[50:35];
    assign w_hall_ok = (w_hall != 3'd0) && (w_hall != 3'd7);

    // stage enables: a stage loads when empty or when its request moves on
    assign w_eno = !r_vo || m_axis_tready;
    assign w_en3 = !r_v3 || w_eno;
    assign w_en2 = !r_v2 || (r_v3 ? w_en3 : 1'b1);
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;
    assign w_acc_in = s_axis_tvalid && w_en1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apc  <= hea_pkg::APC_RESET;
            r_step <= hea_pkg::STEP_RESET;
            r_lim  <= hea_pkg::LIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hea_pkg::REG_ANGLE_PER_COUNT: r_apc  <= i_cfg_data[hea_pkg::APC_W-1:0];
                hea_pkg::REG_STARTUP_STEP:    r_step <= i_cfg_data[hea_pkg::STEP_W-1:0];
                hea_pkg::REG_UQ_LIMIT:        r_lim  <= i_cfg_data[hea_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // mode decisions at accept: next control state, multiplier operand, op
    always_comb begin
        n_mode       = r_mode;
        n_last_hall  = r_last_hall;
        n_edge_angle = r_edge_angle;
        n_edge_count = r_edge_count;
        n_d          = w_enc;
        n_ctl.op     = hea_pkg::OP_HOLD;
        n_ctl.addend = r_edge_angle;
        case (w_cmd)
            hea_pkg::CMD_START: begin
                n_mode       = hea_pkg::MODE_HALL;
                n_last_hall  = w_hall;
                n_edge_angle = '0;
                n_edge_count = w_enc;
                n_ctl.op     = hea_pkg::OP_LOAD;
                n_ctl.addend = hea_pkg::centre_angle(w_hall);
            end
            hea_pkg::CMD_INDEX: begin
                if (r_mode != hea_pkg::MODE_ENC) begin
                    n_mode   = hea_pkg::MODE_ENC;
                    n_ctl.op = hea_pkg::OP_INDEX;
                end
            end
            hea_pkg::CMD_TICK: begin
                if (r_mode == hea_pkg::MODE_ENC) begin
                    n_ctl.op = hea_pkg::OP_ENC;
                end else if (r_mode == hea_pkg::MODE_HALL) begin
                    if (w_hall_ok && (w_hall != r_last_hall)) begin
                        // first hall edge: capture it, angle holds this tick
                        n_last_hall  = w_hall;
                        n_edge_angle = hea_pkg::edge_angle(w_hall);
                        n_edge_count = w_enc;
                        n_mode       = hea_pkg::MODE_EDGE;
                    end else begin
                        n_ctl.op = hea_pkg::OP_STEP;
                    end
                end else begin
                    n_ctl.op = hea_pkg::OP_EDGE;
                    n_d      = w_enc - r_edge_count;
                end
            end
            default: ;
        endcase
        n_ctl.mode = n_mode;

        // q voltage clamp in hall-only mode
        n_ctl.uq = w_uq;
        if (n_mode == hea_pkg::MODE_HALL) begin
            if (w_uq_x > w_lim_x) begin
                n_ctl.uq = w_lim_x[15:0];
            end else if (w_uq_x < w_nlim_x) begin
                n_ctl.uq = w_nlim_x[15:0];
            end
        end
    end

    // widened clamp operands
    assign w_uq_x   = {w_uq[15], w_uq};
    assign w_lim_x  = {2'b00, r_lim};
    assign w_nlim_x = -w_lim_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= hea_pkg::MODE_HALL;
            r_last_hall  <= '0;
            r_edge_angle <= '0;
            r_edge_count <= '0;
        end else if (w_acc_in) begin
            r_mode       <= n_mode;
            r_last_hall  <= n_last_hall;
            r_edge_angle <= n_edge_angle;
            r_edge_count <= n_edge_count;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_eno) r_vo <= r_v3;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_ctl1 <= n_ctl;
            r_d1   <= n_d;
        end
        if (w_en2) r_ctl2 <= r_ctl1;
        if (w_en3) r_ctl3 <= r_ctl2;
    end

    hea_angle_mul u_mul (
        .i_clk   (i_clk),
        .i_en_a  (w_en2),
        .i_en_b  (w_en3),
        .i_count (r_d1),
        .i_scale (r_apc),
        .o_angle (w_prod)
    );

    // accumulator and offset update
    always_comb begin
        n_acc    = r_acc;
        n_offset = r_offset;
        case (r_ctl3.op)
            hea_pkg::OP_LOAD: begin
                n_acc    = r_ctl3.addend;
                n_offset = '0;
            end
            hea_pkg::OP_STEP:  n_acc    = r_acc + {8'd0, r_step};
            hea_pkg::OP_ENC:   n_acc    = w_prod + r_offset;
            hea_pkg::OP_EDGE:  n_acc    = r_ctl3.addend + w_prod;
            hea_pkg::OP_INDEX: n_offset = r_acc - w_prod;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_offset <= '0;
        end else if (w_eno && r_v3) begin
            r_acc    <= n_acc;
            r_offset <= n_offset;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_eno) begin
            r_o_angle <= n_acc;
            r_o_mode  <= r_ctl3.mode;
            r_o_ready <= (r_ctl3.mode == hea_pkg::MODE_ENC);
            r_o_uq    <= r_ctl3.uq;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {5'd0, r_o_uq, r_o_ready, r_o_mode, r_o_angle};

`ifndef SYNTHESIS
    // ready is low only when every stage holds a request
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_vo))
        else $error("input stalled with an empty pipeline stage");

    // a start request always returns the estimator to hall-only mode
    a_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == hea_pkg::CMD_START))
        |=> (r_mode == hea_pkg::MODE_HALL))
        else $error("start did not select hall-only mode");

    // encoder-ready flag agrees with the reported mode
    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[34] == (m_axis_tdata[33:32] == hea_pkg::MODE_ENC)))
        else $error("encoder_ready disagrees with mode");

    // the control mode never takes the unused code
    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == hea_pkg::MODE_HALL) || (r_mode == hea_pkg::MODE_EDGE)
        || (r_mode == hea_pkg::MODE_ENC))
        else $error("illegal mode code");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import hea_pkg::*;

    // spare command code, no state change
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    // hall codes that never mark a sector
    localparam logic [HALL_W-1:0] HALL_OPEN  = 3'b000;
    localparam logic [HALL_W-1:0] HALL_SHORT = 3'b111;

    // sector centre and edge angles, hall code 7 in the top word
    localparam logic [8*ANGLE_W-1:0] SECTOR_CENTRES = {
        32'd0, 32'd3937053355, 32'd1073741824, 32'd357913941,
        32'd2505397589, 32'd3221225472, 32'd1789569707, 32'd0
    };
    localparam logic [8*ANGLE_W-1:0] SECTOR_EDGES = {
        32'd0, 32'd3579139413, 32'd715827883, 32'd0,
        32'd2147483648, 32'd2863311531, 32'd1431655765, 32'd0
    };

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [HALL_W-1:0]  hall;
        logic [COUNT_W-1:0] enc;
        logic [UQ_W-1:0]    uq;
    } t_rotor_req;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [MODE_W-1:0]  mode;
        logic               ready;
        logic [UQ_W-1:0]    uq;
    } t_rotor_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [55:0]           s_axis_tdata = '0;  // hall_bits[2:0], enc_count[34:3], uq_request[50:35]
    logic [1:0]            s_axis_tuser = '0;  // cmd[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [55:0]           m_axis_tdata;       // rotor_angle[31:0], mode_now[33:32],
                                               // encoder_ready[34], uq_out[50:35]

    // estimator mirror: configuration and state
    logic [APC_W-1:0]   cfg_apc = APC_RESET;
    logic [STEP_W-1:0]  cfg_step = STEP_RESET;
    logic [LIM_W-1:0]   cfg_uq_lim = LIM_RESET;
    logic [MODE_W-1:0]  est_mode = MODE_HALL;
    logic [HALL_W-1:0]  est_last_hall = '0;
    logic [ANGLE_W-1:0] est_angle = '0;
    logic [ANGLE_W-1:0] est_edge_angle = '0;
    logic [COUNT_W-1:0] est_edge_count = '0;
    logic [ANGLE_W-1:0] est_offset = '0;

    t_rotor_req pending_reqs[$];
    t_rotor_res expected_results[$];
    int         queued_count = 0;
    int         mismatch_count = 0;
    int         idle_odds = 6;
    int         src_gap = 0;
    int         sink_gap = 0;

    hall_encoder_angle_startup_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // encoder angle: bits 47..16 of signed count times scale
    function automatic logic [ANGLE_W-1:0] counts_to_angle(input logic [COUNT_W-1:0] c);
        logic [63:0] prod;
        prod = {{32{c[31]}}, c} * {16'd0, cfg_apc};
        return prod[47:16];
    endfunction

    // advance the mirror by one request and return its result
    function automatic t_rotor_res predict_rotor(input t_rotor_req r);
        t_rotor_res res;
        int         uq_i;
        int         lim_i;
        case (r.cmd)
            CMD_START: begin
                est_mode       = MODE_HALL;
                est_last_hall  = r.hall;
                est_angle      = SECTOR_CENTRES[{r.hall, 5'd0} +: ANGLE_W];
                est_edge_angle = '0;
                est_edge_count = r.enc;
                est_offset     = '0;
            end
            CMD_INDEX: begin
                if (est_mode != MODE_ENC) begin
                    est_offset = est_angle - counts_to_angle(r.enc);
                    est_mode   = MODE_ENC;
                end
            end
            CMD_TICK: begin
                if (est_mode == MODE_ENC) begin
                    est_angle = counts_to_angle(r.enc) + est_offset;
                end else if (est_mode == MODE_HALL) begin
                    if (r.hall != HALL_OPEN && r.hall != HALL_SHORT
                            && r.hall != est_last_hall) begin
                        // first valid hall change: latch the sector edge
                        est_last_hall  = r.hall;
                        est_edge_angle = SECTOR_EDGES[{r.hall, 5'd0} +: ANGLE_W];
                        est_edge_count = r.enc;
                        est_mode       = MODE_EDGE;
                    end else begin
                        est_angle = est_angle + ANGLE_W'(cfg_step);
                    end
                end else begin
                    est_angle = est_edge_angle + counts_to_angle(r.enc - est_edge_count);
                end
            end
            default: ;
        endcase
        // start-up clamp only in hall-only mode
        uq_i  = $signed(r.uq);
        lim_i = cfg_uq_lim;
        if (est_mode == MODE_HALL) begin
            if (uq_i > lim_i)
                uq_i = lim_i;
            if (uq_i < -lim_i)
                uq_i = -lim_i;
        end
        res.angle = est_angle;
        res.mode  = est_mode;
        res.ready = (est_mode == MODE_ENC);
        res.uq    = uq_i[UQ_W-1:0];
        return res;
    endfunction

    task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [HALL_W-1:0] hall,
                            input logic [COUNT_W-1:0] enc, input logic [UQ_W-1:0] uq);
        t_rotor_req r;
        r.cmd  = cmd;
        r.hall = hall;
        r.enc  = enc;
        r.uq   = uq;
        pending_reqs.push_back(r);
        queued_count++;
    endtask

    // q voltage: full range, extremes and values around the clamp
    function automatic logic [UQ_W-1:0] rand_uq();
        logic [UQ_W-1:0] near;
        near = UQ_W'(cfg_uq_lim) + UQ_W'($urandom_range(0, 2)) - 16'd1;
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return near;
            3: return -near;
            default: return UQ_W'($urandom);
        endcase
    endfunction

    // small encoder movement, now and then a big jump
    function automatic logic [COUNT_W-1:0] nudge_count(input logic [COUNT_W-1:0] enc);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return enc + COUNT_W'($urandom_range(0, 400)) - 32'd200;
    endfunction

    function automatic logic [HALL_W-1:0] bad_hall();
        return $urandom_range(0, 1) ? HALL_SHORT : HALL_OPEN;
    endfunction

    // start-up sequences with random content, mixed with loose requests
    task automatic queue_random_runs(input int n);
        logic [HALL_W-1:0]  h;
        logic [HALL_W-1:0]  nh;
        logic [COUNT_W-1:0] enc;
        int                 target;
        target = queued_count + n;
        enc = $urandom;
        while (queued_count < target) begin
            if ($urandom_range(0, 6) == 0) begin
                push_req(CMD_W'($urandom_range(0, 3)), HALL_W'($urandom), $urandom, rand_uq());
            end else begin
                h = ($urandom_range(0, 9) == 0) ? HALL_W'($urandom)
                                                : HALL_W'($urandom_range(1, 6));
                if ($urandom_range(0, 3) == 0)
                    enc = $urandom;
                push_req(CMD_START, h, enc, rand_uq());
                // creep in hall-only mode
                repeat ($urandom_range(0, 5)) begin
                    enc = nudge_count(enc);
                    push_req(CMD_TICK, ($urandom_range(0, 3) == 0) ? bad_hall() : h,
                             enc, rand_uq());
                end
                if ($urandom_range(0, 7) != 0) begin
                    // hall edge, then edge-plus-encoder ticks
                    nh = HALL_W'($urandom_range(1, 6));
                    if (nh == h)
                        nh = (nh == 3'd6) ? 3'd1 : nh + 3'd1;
                    enc = nudge_count(enc);
                    push_req(CMD_TICK, nh, enc, rand_uq());
                    repeat ($urandom_range(1, 8)) begin
                        enc = nudge_count(enc);
                        push_req(CMD_TICK, HALL_W'($urandom), enc, rand_uq());
                    end
                end
                if ($urandom_range(0, 3) != 0) begin
                    enc = nudge_count(enc);
                    push_req(CMD_INDEX, HALL_W'($urandom), enc, rand_uq());
                    repeat ($urandom_range(1, 8)) begin
                        enc = nudge_count(enc);
                        if ($urandom_range(0, 9) == 0)
                            push_req(CMD_INDEX, HALL_W'($urandom), enc, rand_uq());
                        else
                            push_req(CMD_TICK, HALL_W'($urandom), enc, rand_uq());
                    end
                end
            end
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // all requests sent, all results back, pipeline empty
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // request driver, also mirrors configuration writes
    always @(posedge i_clk) begin : drive_reqs
        t_rotor_req acc;
        t_rotor_req nx;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_PER_COUNT: cfg_apc    = i_cfg_data[APC_W-1:0];
                REG_STARTUP_STEP:    cfg_step   = i_cfg_data[STEP_W-1:0];
                REG_UQ_LIMIT:        cfg_uq_lim = i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc.cmd  = s_axis_tuser;
                acc.hall = s_axis_tdata[2:0];
                acc.enc  = s_axis_tdata[34:3];
                acc.uq   = s_axis_tdata[50:35];
                expected_results.push_back(predict_rotor(acc));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                    src_gap = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    nx = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, nx.uq, nx.enc, nx.hall};
                    s_axis_tuser  <= nx.cmd;
                end
            end
        end
    end

    // result monitor and sink stalls
    always @(posedge i_clk) begin : check_results
        t_rotor_res got;
        t_rotor_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.angle = m_axis_tdata[31:0];
                got.mode  = m_axis_tdata[33:32];
                got.ready = m_axis_tdata[34];
                got.uq    = m_axis_tdata[50:35];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing expected: angle %h mode %0d",
                                 $realtime, got.angle, got.mode);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("%0t: mismatch angle %h/%h mode %0d/%0d ",
                                   $realtime, want.angle, got.angle, want.mode, got.mode);
                            $display("ready %0d/%0d uq %h/%h (expected/actual)",
                                     want.ready, got.ready, want.uq, got.uq);
                        end
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                sink_gap = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: reset state used without a start
        @(negedge i_clk);
        push_req(CMD_TICK, HALL_OPEN, 32'h0000_0000, 16'h7FFF);
        push_req(CMD_TICK, HALL_SHORT, 32'h7FFF_FFFF, 16'h8000);
        push_req(CMD_TICK, 3'd5, 32'd100, 16'h0000);
        push_req(CMD_TICK, 3'd5, 32'h8000_0000, 16'h8000);
        push_req(CMD_TICK, 3'd3, 32'hFFFF_FFFF, 16'h7FFF);
        push_req(CMD_SPARE, 3'd6, 32'd12345, 16'h0005);
        push_req(CMD_INDEX, 3'd2, 32'd1000, 16'h8000);
        push_req(CMD_INDEX, 3'd4, 32'd5, 16'h0001);
        push_req(CMD_TICK, 3'd1, 32'h7FFF_FFFF, 16'h7FFF);
        push_req(CMD_TICK, 3'd0, 32'h8000_0000, 16'hFFFF);
        // a start on every hall code
        for (int h = 0; h < 8; h++)
            push_req(CMD_START, HALL_W'(h), $urandom, 16'h8000);
        push_req(CMD_TICK, HALL_SHORT, 32'd7, 16'h7FFF);
        push_req(CMD_TICK, 3'd1, 32'd9, 16'h8000);
        push_req(CMD_START, 3'd2, 32'hFFFF_FFF0, 16'd3001);
        push_req(CMD_TICK, 3'd2, 32'hFFFF_FFF8, 16'hF447);
        push_req(CMD_INDEX, 3'd2, 32'h0000_0010, 16'h8000);
        push_req(CMD_TICK, 3'd6, 32'h0000_0020, 16'h8000);
        queue_random_runs(200);
        wait_idle();

        // extremes: full scale, no clamp room
        write_cfg(REG_ANGLE_PER_COUNT, {CFG_DATA_W{1'b1}});
        write_cfg(REG_STARTUP_STEP, CFG_DATA_W'({STEP_W{1'b1}}));
        write_cfg(REG_UQ_LIMIT, '0);
        idle_odds = 3;
        @(negedge i_clk);
        queue_random_runs(250);
        wait_idle();

        // extremes: zero scale and step, widest clamp
        write_cfg(REG_ANGLE_PER_COUNT, '0);
        write_cfg(REG_STARTUP_STEP, '0);
        write_cfg(REG_UQ_LIMIT, CFG_DATA_W'({LIM_W{1'b1}}));
        idle_odds = 10;
        @(negedge i_clk);
        queue_random_runs(250);
        wait_idle();

        // random setting
        write_cfg(REG_ANGLE_PER_COUNT, CFG_DATA_W'({$urandom, $urandom}));
        write_cfg(REG_STARTUP_STEP, CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)));
        write_cfg(REG_UQ_LIMIT, CFG_DATA_W'($urandom_range(0, 15'h7FFF)));
        idle_odds = 5;
        @(negedge i_clk);
        queue_random_runs(250);
        wait_idle();

        // default scale again, last stretch without idling
        write_cfg(REG_ANGLE_PER_COUNT, CFG_DATA_W'(APC_RESET));
        write_cfg(REG_STARTUP_STEP, CFG_DATA_W'($urandom_range(0, 24'hFF_FFFF)));
        write_cfg(REG_UQ_LIMIT, CFG_DATA_W'($urandom_range(0, 200)));
        idle_odds = 0;
        @(negedge i_clk);
        queue_random_runs(250);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS hall_encoder_angle_startup_top");
        else
            $display("FAIL hall_encoder_angle_startup_top");
        $finish;
    end

    // run time limit
    initial begin
        #2_000_000;
        $display("FAIL hall_encoder_angle_startup_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/hea_pkg.sv
hdl/hea_angle_mul.sv
hdl/hall_encoder_angle_startup_top.sv
verif/tb.sv
